// ===== hdl/skvma_pkg.sv =====
// Shared types and constants for the sorted key/value merge-add block.
// No dependencies; used by every file under hdl.
`default_nettype none

package skvma_pkg;

    localparam int DEPTH  = 32;
    localparam int KEY_W  = 16;
    localparam int VAL_W  = 16;
    localparam int SUM_W  = VAL_W + 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // one list store's port bundle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FETCH,
        ST_MERGE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/skvma_store.sv =====
// List store: DEPTH entries, one write and one registered read per cycle.
// Depends on skvma_pkg.
`default_nettype none

module skvma_store (
    input  wire logic                  i_clk,
    input  wire skvma_pkg::t_store_req i_req,
    output skvma_pkg::t_entry          o_rdata
);

    skvma_pkg::t_entry r_mem [skvma_pkg::DEPTH];
    skvma_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/sorted_key_value_merge_add.sv =====
// Sorted key/value merge-add: loads two ascending lists, then merges them,
// summing the values of shared keys. Depends on skvma_pkg and skvma_store.
//
// Usage: send entries one request per cycle; list_id picks the list and
// end_of_list closes it. Loading accepts one request per cycle. The request
// that closes the second list starts the merge, during which o_in_stall is
// high. For each result the merge reads both list stores in a fetch state,
// then does the shared key compare and value add in a merge state, which
// waits while the output is stalled; the input stays stalled until the final
// result is made. The final result carries last_in_run and then all list state is
// cleared; overflow is set on every result of a run in which an entry was
// dropped (list full, or list already closed). Keys are not checked for
// order. The output register lets loading of the next run start while the
// final result still waits to be taken.
`default_nettype none

module sorted_key_value_merge_add (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input requests
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_list_id,
    input  wire logic [skvma_pkg::KEY_W-1:0]   i_key,
    input  wire logic [skvma_pkg::VAL_W-1:0]   i_value,
    input  wire logic                          i_end_of_list,
    // result requests
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [skvma_pkg::KEY_W-1:0]        o_out_key,
    output logic [skvma_pkg::SUM_W-1:0]        o_out_sum,
    output logic                               o_last_in_run,
    output logic                               o_overflow
);

    localparam int CW = skvma_pkg::CNT_W;
    localparam int AW = skvma_pkg::ADDR_W;

    skvma_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt0, n_cnt0, r_cnt1, n_cnt1;
    logic          r_closed0, n_closed0, r_closed1, n_closed1;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_i, n_i, r_j, n_j;

    logic                        r_out_valid, n_out_valid;
    logic [skvma_pkg::KEY_W-1:0] r_out_key, n_out_key;
    logic [skvma_pkg::SUM_W-1:0] r_out_sum, n_out_sum;
    logic                        r_out_last, n_out_last;
    logic                        r_out_ovf, n_out_ovf;

    skvma_pkg::t_store_req req0, req1;
    skvma_pkg::t_entry     rd0, rd1;

    logic          accept_in, sel_closed, sel_full, writing;
    logic [CW-1:0] sel_cnt;
    logic          a_ok, b_ok, k_lt, k_eq, take_a, take_b, out_free, is_last;
    logic [skvma_pkg::SUM_W-1:0] add_a, add_b;
    logic [CW-1:0] step_i, step_j;

    // ---- list stores ----
    skvma_store u_store0 (.i_clk(i_clk), .i_req(req0), .o_rdata(rd0));
    skvma_store u_store1 (.i_clk(i_clk), .i_req(req1), .o_rdata(rd1));

    // ---- loading ----
    assign accept_in  = i_in_valid && (r_state == skvma_pkg::ST_LOAD);
    assign sel_closed = i_list_id ? r_closed1 : r_closed0;
    assign sel_cnt    = i_list_id ? r_cnt1 : r_cnt0;
    assign sel_full   = (sel_cnt >= CW'(skvma_pkg::DEPTH));
    assign writing    = accept_in && !sel_closed && !sel_full;

    always_comb begin
        req0.we    = writing && !i_list_id;
        req0.waddr = r_cnt0[AW-1:0];
        req0.wdata = '{key: i_key, value: i_value};
        req0.raddr = r_i[AW-1:0];
        req1.we    = writing && i_list_id;
        req1.waddr = r_cnt1[AW-1:0];
        req1.wdata = '{key: i_key, value: i_value};
        req1.raddr = r_j[AW-1:0];
    end

    // ---- shared compare / add unit ----
    assign a_ok   = (r_i < r_cnt0);
    assign b_ok   = (r_j < r_cnt1);
    assign k_lt   = (rd0.key < rd1.key);
    assign k_eq   = (rd0.key == rd1.key);
    assign take_a = a_ok && (!b_ok || k_eq || k_lt);
    assign take_b = b_ok && (!a_ok || k_eq || !k_lt);
    assign add_a  = take_a ? {1'b0, rd0.value} : '0;
    assign add_b  = take_b ? {1'b0, rd1.value} : '0;
    assign step_i = r_i + CW'(take_a);
    assign step_j = r_j + CW'(take_b);
    assign is_last = !((step_i < r_cnt0) || (step_j < r_cnt1));

    assign out_free = !r_out_valid || !i_out_stall;

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_cnt0      = r_cnt0;
        n_cnt1      = r_cnt1;
        n_closed0   = r_closed0;
        n_closed1   = r_closed1;
        n_drop      = r_drop;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_key   = r_out_key;
        n_out_sum   = r_out_sum;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            skvma_pkg::ST_LOAD: begin
                if (accept_in) begin
                    if (sel_closed || sel_full) begin
                        n_drop = 1'b1;
                    end
                    if (writing && !i_list_id) begin
                        n_cnt0 = r_cnt0 + CW'(1);
                    end
                    if (writing && i_list_id) begin
                        n_cnt1 = r_cnt1 + CW'(1);
                    end
                    // end mark only counts on an open list
                    if (!sel_closed && i_end_of_list) begin
                        if (i_list_id) begin
                            n_closed1 = 1'b1;
                        end else begin
                            n_closed0 = 1'b1;
                        end
                    end
                    if (n_closed0 && n_closed1) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = skvma_pkg::ST_FETCH;
                    end
                end
            end
            skvma_pkg::ST_FETCH: begin
                n_state = skvma_pkg::ST_MERGE;
            end
            skvma_pkg::ST_MERGE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_key   = take_a ? rd0.key : rd1.key;
                    n_out_sum   = add_a + add_b;
                    n_out_last  = is_last;
                    n_out_ovf   = r_drop;
                    n_i         = step_i;
                    n_j         = step_j;
                    if (is_last) begin
                        n_cnt0    = '0;
                        n_cnt1    = '0;
                        n_closed0 = 1'b0;
                        n_closed1 = 1'b0;
                        n_drop    = 1'b0;
                        n_state   = skvma_pkg::ST_LOAD;
                    end else begin
                        n_state = skvma_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = skvma_pkg::ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skvma_pkg::ST_LOAD;
            r_cnt0      <= '0;
            r_cnt1      <= '0;
            r_closed0   <= 1'b0;
            r_closed1   <= 1'b0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt0      <= n_cnt0;
            r_cnt1      <= n_cnt1;
            r_closed0   <= n_closed0;
            r_closed1   <= n_closed1;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // merge pointers and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_out_key  <= n_out_key;
        r_out_sum  <= n_out_sum;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_in_stall    = (r_state != skvma_pkg::ST_LOAD);
    assign o_out_valid   = r_out_valid;
    assign o_out_key     = r_out_key;
    assign o_out_sum     = r_out_sum;
    assign o_last_in_run = r_out_last;
    assign o_overflow    = r_out_ovf;

endmodule

`default_nettype wire

// ===== hdl/skvma_checker.sv =====
// Port-level checks for sorted_key_value_merge_add, bound to the top level.
// Depends on skvma_pkg.
`default_nettype none

module skvma_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [skvma_pkg::KEY_W-1:0] o_out_key,
    input wire logic [skvma_pkg::SUM_W-1:0] o_out_sum,
    input wire logic                        o_last_in_run
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_key) && $stable(o_out_sum))
        else $error("stalled result changed or vanished");

    // when the final result first appears, loading is open again; a later
    // run may close both lists while it still waits
    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) ##1 (o_out_valid && o_last_in_run)
            |-> !o_in_stall)
        else $error("input still stalled after final result");

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // mid-run results come from the merge, so input is stalled meanwhile
    a_merge_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && !o_last_in_run |-> o_in_stall)
        else $error("input open during merge");

endmodule

bind sorted_key_value_merge_add skvma_checker u_skvma_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_key    (o_out_key),
    .o_out_sum    (o_out_sum),
    .o_last_in_run(o_last_in_run)
);

`default_nettype wire
